// ----- sv/bmu_pkg.sv -----
package bmu_pkg;

   localparam int NUM_MAILBOXES_DEF = 8;
   localparam int MAIL_DEPTH_DEF    = 16;
   localparam int WAIT_DEPTH_DEF    = 4;
   localparam int PAYLOAD_WIDTH     = 32;

   localparam logic [2:0] MODE_CREATE  = 3'd0;
   localparam logic [2:0] MODE_DESTROY = 3'd1;
   localparam logic [2:0] MODE_SEND    = 3'd2;
   localparam logic [2:0] MODE_RECV    = 3'd3;
   localparam logic [2:0] MODE_CHECK   = 3'd4;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_INVALID   = 4'd1;
   localparam logic [3:0] ST_NOT_FOUND = 4'd2;
   localparam logic [3:0] ST_NO_FREE   = 4'd3;
   localparam logic [3:0] ST_FULL      = 4'd4;
   localparam logic [3:0] ST_EMPTY     = 4'd5;
   localparam logic [3:0] ST_PARKED    = 4'd6;
   localparam logic [3:0] ST_BLOCKED   = 4'd7;
   localparam logic [3:0] ST_WAIT_FULL = 4'd8;

   typedef struct packed {
      logic [2:0]               mode;
      logic [15:0]              mailbox_id;
      logic [4:0]               capacity;
      logic                     blocking;
      logic [7:0]               source_pid;
      logic [PAYLOAD_WIDTH-1:0] payload;
      logic [15:0]              msg_bytes;
   } req_type;

   typedef struct packed {
      logic [3:0]               status;
      logic [15:0]              ret_value;
      logic [PAYLOAD_WIDTH-1:0] mail_payload;
      logic [15:0]              mail_size;
      logic [7:0]               mail_source;
      logic                     woken_valid;
      logic [7:0]               woken_pid;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_RD_MAIL,
      S_RD_WAIT,
      S_WAIT_DATA,
      S_PUSH_WOKEN,
      S_DONE
   } state_type;

endpackage

// ----- sv/bmu_ram.sv -----
module bmu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- sv/bounded_mailbox_unit.sv -----
// A request passes through a slot scan of one slot per cycle over all NUM_MAILBOXES slots,
// a decide step and a done step; a receive that finds mail adds a read-address step and a
// read-data step, and a push step when a parked sender is moved in. A new request is
// accepted only from idle, once the previous request has finished.
// Reset: synchronous, active high; clears slot valid bits, queue pointers and counters.
// The receiver cannot stall: each result is presented for exactly one cycle.
module bounded_mailbox_unit #(
   parameter int NUM_MAILBOXES = bmu_pkg::NUM_MAILBOXES_DEF,
   parameter int MAIL_DEPTH    = bmu_pkg::MAIL_DEPTH_DEF,
   parameter int WAIT_DEPTH    = bmu_pkg::WAIT_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bmu_pkg::req_type  req_data,
   output logic              rsp_valid,
   output bmu_pkg::rsp_type  rsp_data
);
   import bmu_pkg::*;

   localparam int SW = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
   localparam int MW = (MAIL_DEPTH > 1) ? $clog2(MAIL_DEPTH) : 1;
   localparam int WW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int CW = $clog2(MAIL_DEPTH + 1);
   localparam int QW = $clog2(WAIT_DEPTH + 1);
   localparam int OW = $clog2(NUM_MAILBOXES + 1);
   localparam int TSW = CW + 1;
   localparam int WSW = QW + 1;
   localparam int MSGW = PAYLOAD_WIDTH + 24;
   localparam int MAW = SW + MW;
   localparam int WAW = SW + WW;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;

   logic [NUM_MAILBOXES-1:0] slot_valid_ff, slot_valid_in;
   logic [15:0]   slot_ident_ff [NUM_MAILBOXES];
   logic [CW-1:0] slot_cap_ff   [NUM_MAILBOXES];
   logic [MW-1:0] mail_head_ff  [NUM_MAILBOXES];
   logic [CW-1:0] mail_count_ff [NUM_MAILBOXES];
   logic [WW-1:0] wait_head_ff  [NUM_MAILBOXES];
   logic [QW-1:0] wait_count_ff [NUM_MAILBOXES];
   logic [15:0]   last_ident_ff;
   logic [OW-1:0] open_count_ff;

   // Scan registers: slot counter, match and free results.
   logic [OW-1:0] scan_ff, scan_in;
   logic          hit_ff, hit_in, free_ok_ff, free_ok_in;
   logic [SW-1:0] hit_slot_ff, hit_slot_in, free_slot_ff, free_slot_in;
   logic [MSGW-1:0] woken_msg_ff, woken_msg_in;

   // Memory ports.
   logic            m_we, w_we;
   logic [MAW-1:0]  m_waddr, m_raddr;
   logic [WAW-1:0]  w_waddr, w_raddr;
   logic [MSGW-1:0] m_wdata, m_rdata, w_wdata, w_rdata;

   bmu_ram #(.WIDTH(MSGW), .DEPTH(1 << MAW)) u_mail_ram (
      .clock(clock), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
      .rd_addr(m_raddr), .rd_data(m_rdata)
   );
   bmu_ram #(.WIDTH(MSGW), .DEPTH(1 << WAW)) u_wait_ram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(w_wdata),
      .rd_addr(w_raddr), .rd_data(w_rdata)
   );

   // Per-slot update controls from the sequencer.
   logic          clr_slot, create_slot, push_mail, pop_mail, push_wait, pop_wait;
   logic [SW-1:0] tgt;
   logic [MSGW-1:0] req_msg;
   logic [CW-1:0] cap_sat;
   logic [CW-1:0] cnt_t, cap_t;
   logic [QW-1:0] wcnt_t;
   logic [MW-1:0] head_t;
   logic [WW-1:0] whead_t;
   logic [15:0]   next_ident;
   logic [TSW-1:0] tail_sum;
   logic [WSW-1:0] wtail_sum;
   logic [MW-1:0] tail_pos;
   logic [WW-1:0] wtail_pos;
   logic          id_zero, mode_bad;

   assign req_msg = {req_ff.payload, req_ff.msg_bytes, req_ff.source_pid};
   assign cap_sat = (32'(req_ff.capacity) > MAIL_DEPTH) ? CW'(MAIL_DEPTH)
                                                       : CW'(req_ff.capacity);
   assign cnt_t   = mail_count_ff[tgt];
   assign cap_t   = slot_cap_ff[tgt];
   assign wcnt_t  = wait_count_ff[tgt];
   assign head_t  = mail_head_ff[tgt];
   assign whead_t = wait_head_ff[tgt];
   assign next_ident = (last_ident_ff == 16'hFFFF) ? 16'd1 : last_ident_ff + 16'd1;

   // Tail positions wrap by one compare and subtract.
   assign tail_sum  = TSW'(head_t) + TSW'(cnt_t);
   assign wtail_sum = WSW'(whead_t) + WSW'(wcnt_t);
   assign tail_pos  = (tail_sum >= TSW'(MAIL_DEPTH)) ? MW'(tail_sum - TSW'(MAIL_DEPTH))
                                                     : MW'(tail_sum);
   assign wtail_pos = (wtail_sum >= WSW'(WAIT_DEPTH)) ? WW'(wtail_sum - WSW'(WAIT_DEPTH))
                                                      : WW'(wtail_sum);
   assign id_zero  = (req_ff.mailbox_id == 16'd0);
   assign mode_bad = (req_ff.mode > MODE_CHECK);

   function automatic logic [MW-1:0] inc_m(input logic [MW-1:0] v);
      inc_m = (v == MW'(MAIL_DEPTH - 1)) ? '0 : v + MW'(1);
   endfunction
   function automatic logic [WW-1:0] inc_w(input logic [WW-1:0] v);
      inc_w = (v == WW'(WAIT_DEPTH - 1)) ? '0 : v + WW'(1);
   endfunction

   // Sequencer: the slot scan, the decision and the memory steps.
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      free_ok_in   = free_ok_ff;
      free_slot_in = free_slot_ff;
      woken_msg_in = woken_msg_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      clr_slot = 1'b0; create_slot = 1'b0; push_mail = 1'b0; pop_mail = 1'b0;
      push_wait = 1'b0; pop_wait = 1'b0;
      tgt = hit_slot_ff;
      m_we = 1'b0; w_we = 1'b0;
      m_waddr = {tgt, tail_pos}; m_wdata = req_msg;
      m_raddr = {tgt, head_t};
      w_waddr = {tgt, wtail_pos}; w_wdata = req_msg;
      w_raddr = {tgt, whead_t};
      unique case (state_ff)
         S_IDLE: begin
            scan_in = '0; hit_in = 1'b0; free_ok_in = 1'b0;
            if (start) state_in = S_SCAN;
         end
         S_SCAN: begin
            // One slot per cycle; lowest match and lowest free slot win.
            if (slot_valid_ff[scan_ff[SW-1:0]] &&
                slot_ident_ff[scan_ff[SW-1:0]] == req_ff.mailbox_id && !hit_ff) begin
               hit_in = 1'b1; hit_slot_in = scan_ff[SW-1:0];
            end
            if (!slot_valid_ff[scan_ff[SW-1:0]] && !free_ok_ff) begin
               free_ok_in = 1'b1; free_slot_in = scan_ff[SW-1:0];
            end
            scan_in = scan_ff + OW'(1);
            if (scan_ff == OW'(NUM_MAILBOXES - 1)) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            rsp_in = '0;
            state_in = S_DONE;
            if (mode_bad) begin
               rsp_in.status = ST_INVALID;
            end else if (req_ff.mode == MODE_CREATE) begin
               tgt = free_slot_ff;
               if (open_count_ff >= OW'(NUM_MAILBOXES) || !free_ok_ff) begin
                  rsp_in.status = ST_NO_FREE;
               end else begin
                  create_slot = 1'b1;
                  rsp_in.ret_value = next_ident;
               end
            end else if (req_ff.mode == MODE_DESTROY) begin
               if (id_zero || !hit_ff) rsp_in.status = ST_NOT_FOUND;
               else clr_slot = 1'b1;
            end else if (id_zero) begin
               rsp_in.status = ST_INVALID;
            end else if (!hit_ff) begin
               rsp_in.status = ST_NOT_FOUND;
            end else if (req_ff.mode == MODE_SEND) begin
               if (cnt_t >= cap_t) begin
                  rsp_in.ret_value = 16'(cnt_t);
                  if (!req_ff.blocking) rsp_in.status = ST_FULL;
                  else if (wcnt_t >= QW'(WAIT_DEPTH)) rsp_in.status = ST_WAIT_FULL;
                  else begin
                     w_we = 1'b1; push_wait = 1'b1;
                     rsp_in.status = ST_PARKED;
                  end
               end else begin
                  m_we = 1'b1; push_mail = 1'b1;
                  rsp_in.ret_value = 16'(cnt_t + CW'(1));
               end
            end else if (req_ff.mode == MODE_RECV) begin
               if (cnt_t == '0) begin
                  rsp_in.status = req_ff.blocking ? ST_BLOCKED : ST_EMPTY;
               end else begin
                  state_in = S_RD_MAIL;
               end
            end else begin
               rsp_in.ret_value = 16'(cnt_t);
            end
         end
         S_RD_MAIL: begin
            // Read addresses are presented here; data arrives next cycle.
            state_in = S_WAIT_DATA;
         end
         S_WAIT_DATA: begin
            rsp_in.mail_payload = m_rdata[MSGW-1:24];
            rsp_in.mail_size    = m_rdata[23:8];
            rsp_in.mail_source  = m_rdata[7:0];
            pop_mail = 1'b1;
            if (wcnt_t != '0 && (cnt_t - CW'(1)) < cap_t) begin
               woken_msg_in = w_rdata;
               pop_wait = 1'b1;
               state_in = S_PUSH_WOKEN;
            end else begin
               rsp_in.ret_value = 16'(cnt_t - CW'(1));
               state_in = S_DONE;
            end
         end
         S_PUSH_WOKEN: begin
            // Head already moved, count already reduced: tail is correct.
            m_we = 1'b1; m_wdata = woken_msg_ff; push_mail = 1'b1;
            rsp_in.woken_valid = 1'b1;
            rsp_in.woken_pid   = woken_msg_ff[7:0];
            rsp_in.ret_value   = 16'(cnt_t + CW'(1));
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers and per-slot bookkeeping.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         slot_valid_ff <= '0;
         last_ident_ff <= '0;
         open_count_ff <= '0;
         for (int i = 0; i < NUM_MAILBOXES; i++) begin
            mail_head_ff[i]  <= '0;
            mail_count_ff[i] <= '0;
            wait_head_ff[i]  <= '0;
            wait_count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (create_slot) begin
            slot_valid_ff[tgt] <= 1'b1;
            slot_ident_ff[tgt] <= next_ident;
            slot_cap_ff[tgt]   <= cap_sat;
            last_ident_ff      <= next_ident;
            open_count_ff      <= open_count_ff + OW'(1);
         end
         if (clr_slot) begin
            slot_valid_ff[tgt] <= 1'b0;
            if (open_count_ff != '0) open_count_ff <= open_count_ff - OW'(1);
         end
         if (create_slot || clr_slot) begin
            mail_head_ff[tgt]  <= '0;
            mail_count_ff[tgt] <= '0;
            wait_head_ff[tgt]  <= '0;
            wait_count_ff[tgt] <= '0;
         end
         if (push_mail) mail_count_ff[tgt] <= cnt_t + CW'(1);
         if (pop_mail) begin
            mail_head_ff[tgt]  <= inc_m(head_t);
            mail_count_ff[tgt] <= cnt_t - CW'(1);
         end
         if (push_wait) wait_count_ff[tgt] <= wcnt_t + QW'(1);
         if (pop_wait) begin
            wait_head_ff[tgt]  <= inc_w(whead_t);
            wait_count_ff[tgt] <= wcnt_t - QW'(1);
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (start && !busy) req_ff <= req_data;
      rsp_ff       <= rsp_in;
      scan_ff      <= scan_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      free_ok_ff   <= free_ok_in;
      free_slot_ff <= free_slot_in;
      woken_msg_ff <= woken_msg_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // A result strobe is always the cycle after the done step.
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_DONE)) else $error("strobe without done");
   // The block stays busy after accepting a beat.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("not busy after accept");
   // The open count always equals the number of live slots.
   a_open: assert property (@(posedge clock) disable iff (reset)
      open_count_ff == OW'($countones(slot_valid_ff))) else $error("open count drift");
`endif
endmodule
